>>> hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the pooled linked list engine
// Operation codes, cursor positions, status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DEF_LIST_HEADS = 16;
   localparam int DEF_NODE_POOL  = 256;
   localparam int DEF_ITEM_BITS  = 32;

   typedef enum logic [3:0] {
      FN_CREATE  = 4'd0,
      FN_COUNT   = 4'd1,
      FN_FIRST   = 4'd2,
      FN_LAST    = 4'd3,
      FN_NEXT    = 4'd4,
      FN_PREV    = 4'd5,
      FN_CURRENT = 4'd6,
      FN_ADD     = 4'd7,
      FN_INSERT  = 4'd8,
      FN_APPEND  = 4'd9,
      FN_PREPEND = 4'd10,
      FN_REMOVE  = 4'd11,
      FN_TRIM    = 4'd12,
      FN_CONCAT  = 4'd13,
      FN_FREE    = 4'd14
   } func_type;

   typedef enum logic [1:0] {
      POS_ON     = 2'd0,
      POS_BEFORE = 2'd1,
      POS_PAST   = 2'd2
   } pos_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_NODE_EMPTY = 2'd1,
      STS_LIST_EMPTY = 2'd2,
      STS_NOT_USED   = 2'd3
   } sts_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_LOAD2,
      S_READ1,
      S_READ2,
      S_WRITE1,
      S_WRITE2,
      S_STORE
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic load;
      logic load2;
      logic read1;
      logic read2;
      logic write1;
      logic write2;
      logic store;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_concat;
      logic rsp_free;
   } stat_type;

endpackage

>>> hdl/pooled_linked_list_engine.sv
// ----------------------------------------------------------------------------
// pooled_linked_list_engine: doubly linked lists over a shared node pool
// Each transaction runs the phase sequence load, read, read, write, write,
//   store over the node memories, with a second load for concat.
// One transaction at a time: a new request is taken only after the last one
//   is stored; a held response stalls the store phase.
// Reset: synchronous; a clearing pass initialises the node link memories,
//   during which no transaction is accepted.
// ----------------------------------------------------------------------------
module pooled_linked_list_engine
   import ple_pkg::*;
#(
   parameter int LIST_HEADS = DEF_LIST_HEADS,
   parameter int NODE_POOL  = DEF_NODE_POOL,
   parameter int ITEM_BITS  = DEF_ITEM_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_func,
   input  logic [3:0]           req_list_id,
   input  logic [3:0]           req_other_list_id,
   input  logic [ITEM_BITS-1:0] req_item_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ITEM_BITS-1:0] rsp_result_item,
   output logic                 rsp_item_present,
   output logic [1:0]           rsp_status,
   output logic [8:0]           rsp_item_count,
   output logic [3:0]           rsp_new_list
);

   cmd_type  cmd;
   stat_type stat;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ple_datapath #(
      .LIST_HEADS (LIST_HEADS),
      .NODE_POOL  (NODE_POOL),
      .ITEM_BITS  (ITEM_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_list_id       (req_list_id),
      .req_other_list_id (req_other_list_id),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_item   (rsp_result_item),
      .rsp_item_present  (rsp_item_present),
      .rsp_status        (rsp_status),
      .rsp_item_count    (rsp_item_count),
      .rsp_new_list      (rsp_new_list)
   );

endmodule

>>> hdl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: operation sequencer
// Walks the clearing pass after reset and each transaction's phase sequence,
// issuing one phase strobe per cycle to the datapath while store is not held.
// ----------------------------------------------------------------------------
module ple_ctrl
   import ple_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = stat.is_concat ? S_LOAD2 : S_READ1;
         end
         S_LOAD2: begin
            cmd.load2 = 1'b1;
            state_in  = S_READ1;
         end
         S_READ1: begin
            cmd.read1 = 1'b1;
            state_in  = S_READ2;
         end
         S_READ2: begin
            cmd.read2 = 1'b1;
            state_in  = S_WRITE1;
         end
         S_WRITE1: begin
            cmd.write1 = 1'b1;
            state_in   = S_WRITE2;
         end
         S_WRITE2: begin
            cmd.write2 = 1'b1;
            state_in   = S_STORE;
         end
         S_STORE: begin
            if (stat.rsp_free) begin
               cmd.store = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_clear_leads_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && stat.clear_done) |=> state_ff == S_IDLE)
      else $error("clearing pass did not end in idle");

   a_store_leads_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> (state_ff == S_IDLE))
      else $error("store phase not followed by idle");

   a_load2_only_concat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD2) |-> $past(stat.is_concat))
      else $error("second head loaded for a non concat transaction");

endmodule

>>> hdl/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath: list heads, node memories and pools
// Holds the head registers, the free head stack, the node link and payload
// memories and the response register; executes the phase strobes.
// ----------------------------------------------------------------------------
module ple_datapath
   import ple_pkg::*;
#(
   parameter int LIST_HEADS = DEF_LIST_HEADS,
   parameter int NODE_POOL  = DEF_NODE_POOL,
   parameter int ITEM_BITS  = DEF_ITEM_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [3:0]           req_func,
   input  logic [3:0]           req_list_id,
   input  logic [3:0]           req_other_list_id,
   input  logic [ITEM_BITS-1:0] req_item_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ITEM_BITS-1:0] rsp_result_item,
   output logic                 rsp_item_present,
   output logic [1:0]           rsp_status,
   output logic [8:0]           rsp_item_count,
   output logic [3:0]           rsp_new_list
);

   localparam int NB = $clog2(NODE_POOL + 1);
   localparam int AB = $clog2(NODE_POOL);
   localparam int HB = (LIST_HEADS > 1) ? $clog2(LIST_HEADS) : 1;
   localparam int CB = $clog2(LIST_HEADS + 1);
   localparam logic [NB-1:0] NULL_N = NB'(NODE_POOL);
   localparam logic [AB-1:0] LAST_A = AB'(NODE_POOL - 1);

   // head registers
   logic [NB-1:0] hd_first_ff [LIST_HEADS];
   logic [NB-1:0] hd_last_ff  [LIST_HEADS];
   logic [NB-1:0] hd_cur_ff   [LIST_HEADS];
   pos_type       hd_pos_ff   [LIST_HEADS];
   logic [NB-1:0] hd_len_ff   [LIST_HEADS];
   logic [LIST_HEADS-1:0] hd_use_ff;

   // pools
   logic [HB-1:0] fh_stack_ff [LIST_HEADS];
   logic [CB-1:0] fh_cnt_ff;
   logic [NB-1:0] free_top_ff, free_tot_ff;
   logic [AB-1:0] clr_ff;

   // node memories
   logic [NB-1:0]        fwd_mem [NODE_POOL];
   logic [NB-1:0]        bwd_mem [NODE_POOL];
   logic [ITEM_BITS-1:0] pay_mem [NODE_POOL];
   logic [NB-1:0]        fwd_q, bwd_q;
   logic [ITEM_BITS-1:0] pay_q;

   // transaction
   logic [3:0]           func_ff, hid_ff, oid_ff;
   logic [ITEM_BITS-1:0] item_ff;
   logic                 bad_ff, obad_ff, act_ff, step_ff, empty_ff, after_ff;
   logic [NB-1:0]        w_first_ff, w_last_ff, w_cur_ff, w_len_ff;
   pos_type              w_pos_ff;
   logic [NB-1:0]        o_first_ff, o_last_ff, o_cur_ff, o_len_ff;
   pos_type              o_pos_ff;
   logic [NB-1:0]        n_ff, ref_ff, nx_ff, pv_ff, c_ff;
   logic [ITEM_BITS-1:0] res_ff;
   logic                 pres_ff;
   sts_type              sts_ff;
   logic [HB-1:0]        new_ff;

   // response
   logic                 rsp_valid_ff;
   logic [ITEM_BITS-1:0] rsp_item_ff;
   logic                 rsp_pres_ff;
   logic [1:0]           rsp_sts_ff;
   logic [8:0]           rsp_cnt_ff;
   logic [3:0]           rsp_new_ff;

   logic [HB-1:0] hidx, oidx, hr_idx;
   logic          hr_ok;
   logic [CB-1:0] fh_dec;
   logic          cur_on, cat_ok, fin_write, fin_release;
   logic [AB-1:0] rd_addr;
   logic          fwd_we, bwd_we, pay_we;
   logic [AB-1:0] fwd_wa, bwd_wa, pay_wa;
   logic [NB-1:0] fwd_wd, bwd_wd;
   logic [NB-1:0] fin_first, fin_last, fin_cur, fin_len, len_dec;
   pos_type       fin_pos;
   logic [NB-1:0] step_c;

   assign hidx   = HB'(hid_ff);
   assign oidx   = HB'(oid_ff);
   assign hr_idx = cmd.load2 ? oidx : hidx;
   assign hr_ok  = (int'(cmd.load2 ? oid_ff : hid_ff) < LIST_HEADS) && hd_use_ff[hr_idx];
   assign fh_dec = fh_cnt_ff - CB'(1);
   assign cur_on = (w_pos_ff == POS_ON) && (w_cur_ff != NULL_N);
   assign cat_ok = !bad_ff && !obad_ff && (hid_ff != oid_ff);
   assign len_dec = w_len_ff - NB'(1);
   assign step_c  = (func_ff == FN_NEXT) ? fwd_q : bwd_q;

   assign stat.clear_done = (clr_ff == LAST_A);
   assign stat.is_concat  = (func_ff == FN_CONCAT);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // read address
   always_comb begin
      rd_addr = '0;
      if (cmd.read1) begin
         case (func_ff)
            FN_FIRST:   rd_addr = w_first_ff[AB-1:0];
            FN_LAST:    rd_addr = w_last_ff[AB-1:0];
            FN_NEXT:    rd_addr = cur_on ? w_cur_ff[AB-1:0] : w_first_ff[AB-1:0];
            FN_PREV:    rd_addr = cur_on ? w_cur_ff[AB-1:0] : w_last_ff[AB-1:0];
            FN_CURRENT: rd_addr = w_cur_ff[AB-1:0];
            FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: rd_addr = free_top_ff[AB-1:0];
            FN_REMOVE:  rd_addr = w_cur_ff[AB-1:0];
            FN_TRIM:    rd_addr = w_last_ff[AB-1:0];
            default:    rd_addr = '0;
         endcase
      end else if (cmd.read2) begin
         case (func_ff)
            FN_NEXT, FN_PREV: rd_addr = step_c[AB-1:0];
            FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: rd_addr = ref_ff[AB-1:0];
            default: rd_addr = '0;
         endcase
      end
   end

   // write ports
   always_comb begin
      fwd_we = 1'b0; fwd_wa = '0; fwd_wd = NULL_N;
      bwd_we = 1'b0; bwd_wa = '0; bwd_wd = NULL_N;
      pay_we = 1'b0; pay_wa = '0;
      if (cmd.clear) begin
         fwd_we = 1'b1; fwd_wa = clr_ff;
         bwd_we = 1'b1; bwd_wa = clr_ff;
         bwd_wd = (clr_ff == '0) ? NULL_N : (NB'(clr_ff) - NB'(1));
      end else if (cmd.write1) begin
         case (func_ff)
            FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: begin
               if (act_ff) begin
                  fwd_we = 1'b1; fwd_wa = n_ff[AB-1:0];
                  fwd_wd = empty_ff ? NULL_N : (after_ff ? fwd_q : ref_ff);
                  bwd_we = 1'b1; bwd_wa = n_ff[AB-1:0];
                  bwd_wd = empty_ff ? NULL_N : (after_ff ? ref_ff : bwd_q);
                  pay_we = 1'b1; pay_wa = n_ff[AB-1:0];
               end
            end
            FN_REMOVE: begin
               if (act_ff) begin
                  fwd_we = (pv_ff != NULL_N); fwd_wa = pv_ff[AB-1:0]; fwd_wd = nx_ff;
                  bwd_we = (nx_ff != NULL_N); bwd_wa = nx_ff[AB-1:0]; bwd_wd = pv_ff;
               end
            end
            FN_TRIM: begin
               if (act_ff) begin
                  fwd_we = (pv_ff != NULL_N); fwd_wa = pv_ff[AB-1:0]; fwd_wd = NULL_N;
               end
            end
            FN_CONCAT: begin
               if (cat_ok && o_len_ff != '0 && w_len_ff != '0) begin
                  fwd_we = 1'b1; fwd_wa = w_last_ff[AB-1:0]; fwd_wd = o_first_ff;
                  bwd_we = 1'b1; bwd_wa = o_first_ff[AB-1:0]; bwd_wd = w_last_ff;
               end
            end
            FN_FREE: begin
               if (!bad_ff && w_len_ff != '0 && w_first_ff != NULL_N) begin
                  bwd_we = 1'b1; bwd_wa = w_first_ff[AB-1:0]; bwd_wd = free_top_ff;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.write2) begin
         case (func_ff)
            FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: begin
               if (act_ff && !empty_ff) begin
                  if (after_ff) begin
                     fwd_we = 1'b1; fwd_wa = ref_ff[AB-1:0]; fwd_wd = n_ff;
                     bwd_we = (nx_ff != NULL_N); bwd_wa = nx_ff[AB-1:0]; bwd_wd = n_ff;
                  end else begin
                     bwd_we = 1'b1; bwd_wa = ref_ff[AB-1:0]; bwd_wd = n_ff;
                     fwd_we = (pv_ff != NULL_N); fwd_wa = pv_ff[AB-1:0]; fwd_wd = n_ff;
                  end
               end
            end
            FN_REMOVE, FN_TRIM: begin
               if (act_ff) begin
                  fwd_we = 1'b1; fwd_wa = c_ff[AB-1:0]; fwd_wd = NULL_N;
                  bwd_we = 1'b1; bwd_wa = c_ff[AB-1:0]; bwd_wd = free_top_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
      if (pay_we) pay_mem[pay_wa] <= item_ff;
      fwd_q <= fwd_mem[rd_addr];
      bwd_q <= bwd_mem[rd_addr];
      pay_q <= pay_mem[rd_addr];
   end

   // final head values
   always_comb begin
      fin_first   = w_first_ff;
      fin_last    = w_last_ff;
      fin_cur     = w_cur_ff;
      fin_pos     = w_pos_ff;
      fin_len     = w_len_ff;
      fin_write   = !bad_ff && (func_ff != FN_CREATE) && (func_ff != 4'd15);
      fin_release = 1'b0;
      case (func_ff)
         FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: begin
            if (act_ff) begin
               if (empty_ff) begin
                  fin_first = n_ff;
                  fin_last  = n_ff;
               end else if (after_ff) begin
                  if (nx_ff == NULL_N) fin_last = n_ff;
               end else begin
                  if (pv_ff == NULL_N) fin_first = n_ff;
               end
               fin_cur = n_ff;
               fin_pos = POS_ON;
               fin_len = w_len_ff + NB'(1);
            end
         end
         FN_REMOVE: begin
            if (act_ff) begin
               if (pv_ff == NULL_N) fin_first = nx_ff;
               if (nx_ff == NULL_N) fin_last = pv_ff;
               fin_cur = nx_ff;
               fin_pos = (nx_ff == NULL_N) ? POS_PAST : POS_ON;
               fin_len = len_dec;
            end
         end
         FN_TRIM: begin
            if (act_ff) begin
               fin_last = pv_ff;
               if (pv_ff == NULL_N) fin_first = NULL_N;
               fin_cur = pv_ff;
               fin_pos = POS_ON;
               fin_len = len_dec;
            end
         end
         FN_CONCAT: begin
            if (cat_ok) begin
               fin_release = 1'b1;
               if (o_len_ff != '0) begin
                  if (w_len_ff == '0) begin
                     fin_first = o_first_ff;
                     fin_last  = o_last_ff;
                     fin_cur   = o_cur_ff;
                     fin_pos   = o_pos_ff;
                     fin_len   = o_len_ff;
                  end else begin
                     fin_last = o_last_ff;
                     fin_len  = w_len_ff + o_len_ff;
                  end
               end
            end
         end
         FN_FREE: begin
            fin_len = '0;
         end
         default: begin
         end
      endcase
      // empty list back to its rest state
      if (fin_len == '0) begin
         fin_first = NULL_N;
         fin_last  = NULL_N;
         fin_cur   = NULL_N;
         fin_pos   = POS_BEFORE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIST_HEADS; i++) begin
            hd_first_ff[i] <= NULL_N;
            hd_last_ff[i]  <= NULL_N;
            hd_cur_ff[i]   <= NULL_N;
            hd_pos_ff[i]   <= POS_BEFORE;
            hd_len_ff[i]   <= '0;
            fh_stack_ff[i] <= HB'(i);
         end
         hd_use_ff    <= '0;
         fh_cnt_ff    <= CB'(LIST_HEADS);
         free_top_ff  <= NB'(NODE_POOL - 1);
         free_tot_ff  <= NB'(NODE_POOL);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + AB'(1);
         if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (cmd.accept) begin
            func_ff <= req_func;
            hid_ff  <= req_list_id;
            oid_ff  <= req_other_list_id;
            item_ff <= req_item_value;
         end

         if (cmd.load) begin
            sts_ff     <= STS_OK;
            res_ff     <= '0;
            pres_ff    <= 1'b0;
            act_ff     <= 1'b0;
            step_ff    <= 1'b0;
            obad_ff    <= 1'b0;
            new_ff     <= '0;
            bad_ff     <= 1'b0;
            w_first_ff <= hd_first_ff[hr_idx];
            w_last_ff  <= hd_last_ff[hr_idx];
            w_cur_ff   <= hd_cur_ff[hr_idx];
            w_pos_ff   <= hd_pos_ff[hr_idx];
            w_len_ff   <= hd_len_ff[hr_idx];
            if (func_ff == FN_CREATE) begin
               if (fh_cnt_ff == '0) begin
                  sts_ff <= STS_LIST_EMPTY;
               end else begin
                  new_ff    <= fh_stack_ff[fh_dec[HB-1:0]];
                  fh_cnt_ff <= fh_dec;
                  act_ff    <= 1'b1;
               end
            end else if (func_ff != 4'd15) begin
               if (!hr_ok) begin
                  bad_ff <= 1'b1;
                  sts_ff <= STS_NOT_USED;
               end else if ((func_ff == FN_APPEND || func_ff == FN_PREPEND)
                            && hd_len_ff[hr_idx] != '0) begin
                  w_cur_ff <= (func_ff == FN_APPEND) ? hd_last_ff[hr_idx]
                                                     : hd_first_ff[hr_idx];
                  w_pos_ff <= POS_ON;
               end
            end
         end

         if (cmd.load2) begin
            o_first_ff <= hd_first_ff[hr_idx];
            o_last_ff  <= hd_last_ff[hr_idx];
            o_cur_ff   <= hd_cur_ff[hr_idx];
            o_pos_ff   <= hd_pos_ff[hr_idx];
            o_len_ff   <= hd_len_ff[hr_idx];
            obad_ff    <= !hr_ok;
            if (!bad_ff && !hr_ok) sts_ff <= STS_NOT_USED;
         end

         if (cmd.read1 && !bad_ff) begin
            case (func_ff)
               FN_FIRST, FN_LAST: begin
                  if (w_len_ff != '0) begin
                     w_cur_ff <= (func_ff == FN_FIRST) ? w_first_ff : w_last_ff;
                     w_pos_ff <= POS_ON;
                     act_ff   <= 1'b1;
                  end
               end
               FN_NEXT, FN_PREV: begin
                  if (cur_on) begin
                     act_ff  <= 1'b1;
                     step_ff <= 1'b1;
                  end else if (func_ff == FN_NEXT && w_pos_ff == POS_BEFORE
                               && w_first_ff != NULL_N) begin
                     act_ff   <= 1'b1;
                     w_cur_ff <= w_first_ff;
                     w_pos_ff <= POS_ON;
                  end else if (func_ff == FN_PREV && w_pos_ff == POS_PAST
                               && w_last_ff != NULL_N) begin
                     act_ff   <= 1'b1;
                     w_cur_ff <= w_last_ff;
                     w_pos_ff <= POS_ON;
                  end
               end
               FN_CURRENT: begin
                  if (cur_on) act_ff <= 1'b1;
               end
               FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: begin
                  if (free_tot_ff != '0 && free_top_ff < NULL_N) begin
                     act_ff   <= 1'b1;
                     n_ff     <= free_top_ff;
                     empty_ff <= (w_len_ff == '0) || (w_first_ff == NULL_N);
                     if (w_pos_ff == POS_BEFORE) begin
                        after_ff <= 1'b0;
                        ref_ff   <= w_first_ff;
                     end else if (w_pos_ff == POS_PAST || w_cur_ff == NULL_N) begin
                        after_ff <= 1'b1;
                        ref_ff   <= w_last_ff;
                     end else begin
                        after_ff <= (func_ff == FN_ADD) || (func_ff == FN_APPEND);
                        ref_ff   <= w_cur_ff;
                     end
                  end else begin
                     sts_ff <= STS_NODE_EMPTY;
                  end
               end
               FN_REMOVE: begin
                  if (cur_on) begin
                     act_ff <= 1'b1;
                     c_ff   <= w_cur_ff;
                  end
               end
               FN_TRIM: begin
                  if (w_len_ff != '0 && w_last_ff != NULL_N) begin
                     act_ff <= 1'b1;
                     c_ff   <= w_last_ff;
                  end
               end
               default: begin
               end
            endcase
         end

         if (cmd.read2 && act_ff && !bad_ff) begin
            case (func_ff)
               FN_FIRST, FN_LAST, FN_CURRENT: begin
                  res_ff  <= pay_q;
                  pres_ff <= 1'b1;
               end
               FN_NEXT, FN_PREV: begin
                  if (step_ff) begin
                     w_cur_ff <= step_c;
                     if (step_c == NULL_N) begin
                        w_pos_ff <= (func_ff == FN_NEXT) ? POS_PAST : POS_BEFORE;
                        act_ff   <= 1'b0;
                     end
                  end else begin
                     res_ff  <= pay_q;
                     pres_ff <= 1'b1;
                     act_ff  <= 1'b0;
                  end
               end
               FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: begin
                  free_top_ff <= bwd_q;
                  free_tot_ff <= free_tot_ff - NB'(1);
               end
               FN_REMOVE, FN_TRIM: begin
                  nx_ff   <= fwd_q;
                  pv_ff   <= bwd_q;
                  res_ff  <= pay_q;
                  pres_ff <= 1'b1;
               end
               default: begin
               end
            endcase
         end

         if (cmd.write1) begin
            case (func_ff)
               FN_NEXT, FN_PREV: begin
                  if (act_ff && !bad_ff) begin
                     res_ff  <= pay_q;
                     pres_ff <= 1'b1;
                  end
               end
               FN_ADD, FN_INSERT, FN_APPEND, FN_PREPEND: begin
                  if (act_ff && !bad_ff) begin
                     nx_ff <= fwd_q;
                     pv_ff <= bwd_q;
                  end
               end
               FN_FREE: begin
                  if (!bad_ff && w_len_ff != '0 && w_first_ff != NULL_N) begin
                     free_top_ff <= w_last_ff;
                     free_tot_ff <= free_tot_ff + w_len_ff;
                  end
               end
               default: begin
               end
            endcase
         end

         if (cmd.write2 && act_ff && !bad_ff
             && (func_ff == FN_REMOVE || func_ff == FN_TRIM)) begin
            free_top_ff <= c_ff;
            free_tot_ff <= free_tot_ff + NB'(1);
         end

         if (cmd.store) begin
            if (func_ff == FN_CREATE && act_ff) begin
               hd_first_ff[new_ff] <= NULL_N;
               hd_last_ff[new_ff]  <= NULL_N;
               hd_cur_ff[new_ff]   <= NULL_N;
               hd_pos_ff[new_ff]   <= POS_BEFORE;
               hd_len_ff[new_ff]   <= '0;
               hd_use_ff[new_ff]   <= 1'b1;
            end
            if (fin_write) begin
               hd_first_ff[hidx] <= fin_first;
               hd_last_ff[hidx]  <= fin_last;
               hd_cur_ff[hidx]   <= fin_cur;
               hd_pos_ff[hidx]   <= fin_pos;
               hd_len_ff[hidx]   <= fin_len;
               if (func_ff == FN_FREE) hd_use_ff[hidx] <= 1'b0;
            end
            if (fin_release) begin
               hd_first_ff[oidx] <= NULL_N;
               hd_last_ff[oidx]  <= NULL_N;
               hd_cur_ff[oidx]   <= NULL_N;
               hd_pos_ff[oidx]   <= POS_BEFORE;
               hd_len_ff[oidx]   <= '0;
               hd_use_ff[oidx]   <= 1'b0;
            end
            if ((fin_release || (fin_write && func_ff == FN_FREE))
                && int'(fh_cnt_ff) < LIST_HEADS) begin
               fh_stack_ff[fh_cnt_ff[HB-1:0]] <= fin_release ? oidx : hidx;
               fh_cnt_ff <= fh_cnt_ff + CB'(1);
            end
            rsp_valid_ff <= 1'b1;
            rsp_item_ff  <= res_ff;
            rsp_pres_ff  <= pres_ff;
            rsp_sts_ff   <= sts_ff;
            rsp_cnt_ff   <= fin_write ? 9'(fin_len) : 9'd0;
            rsp_new_ff   <= 4'(new_ff);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_item  = rsp_item_ff;
   assign rsp_item_present = rsp_pres_ff;
   assign rsp_status       = rsp_sts_ff;
   assign rsp_item_count   = rsp_cnt_ff;
   assign rsp_new_list     = rsp_new_ff;

   a_node_total: assert property (@(posedge clock) disable iff (reset)
      int'(free_tot_ff) <= NODE_POOL)
      else $error("free node total above pool size");

   a_head_total: assert property (@(posedge clock) disable iff (reset)
      int'(fh_cnt_ff) <= LIST_HEADS)
      else $error("free head count above head total");

   a_store_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> rsp_valid_ff)
      else $error("stored transaction not presented");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pooled linked list engine
// Drives list operations over the request channel and checks every response
// against a predictor of the lists, the free node stack and the free head
// stack, or typed table rows. A short directed table comes first, then random
// traffic with pool exhaustion phases, bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
   import ple_pkg::*;

   localparam int HEADS = DEF_LIST_HEADS;
   localparam int NODES = DEF_NODE_POOL;
   localparam logic [8:0] NIL = 9'(NODES);
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [3:0] FN_BAD = 4'd15;

   typedef struct packed {
      logic [31:0] item;
      logic        present;
      logic [1:0]  status;
      logic [8:0]  count;
      logic [3:0]  new_list;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  fn;
      logic [3:0]  h;
      logic [3:0]  h2;
      logic [31:0] item;
      logic        typed;
      rsp_type     exp;
   } dir_row_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [3:0] req_func, req_list_id, req_other_list_id;
   logic [31:0] req_item_value;
   logic rsp_valid, rsp_ready;
   logic [31:0] rsp_result_item;
   logic rsp_item_present;
   logic [1:0] rsp_status;
   logic [8:0] rsp_item_count;
   logic [3:0] rsp_new_list;

   pooled_linked_list_engine dut (.*);

   // predicted list state
   logic [8:0]  head_first [HEADS];
   logic [8:0]  head_last  [HEADS];
   logic [8:0]  head_cur   [HEADS];
   pos_type     head_pos   [HEADS];
   logic [8:0]  head_len   [HEADS];
   logic        head_used  [HEADS];
   logic [8:0]  node_fwd   [NODES];
   logic [8:0]  node_bwd   [NODES];
   logic [31:0] node_item  [NODES];
   logic [8:0]  pool_top, pool_total;
   logic [3:0]  head_stack [HEADS];
   int          head_top;

   rsp_type pending_rsp[$];
   int   errors = 0;
   int   cycles = 0;
   int   burst_left = 0;

   function automatic void clear_head(int h);
      head_first[h] = NIL;
      head_last[h]  = NIL;
      head_cur[h]   = NIL;
      head_pos[h]   = POS_BEFORE;
      head_len[h]   = 0;
   endfunction

   function automatic void release_head(int h);
      clear_head(h);
      head_used[h] = 0;
      if (head_top < HEADS - 1) begin
         head_top++;
         head_stack[head_top] = 4'(h);
      end
   endfunction

   function automatic logic [8:0] take_node(logic [31:0] item);
      logic [8:0] n;
      n = pool_top;
      if (pool_total == 0 || n >= NIL) return NIL;
      pool_top = node_bwd[n];
      pool_total--;
      node_fwd[n] = NIL;
      node_bwd[n] = NIL;
      node_item[n] = item;
      return n;
   endfunction

   function automatic void give_node(logic [8:0] n);
      node_fwd[n] = NIL;
      node_bwd[n] = pool_top;
      pool_top = n;
      pool_total++;
   endfunction

   function automatic void link_after(int h, logic [8:0] ref_n, logic [8:0] n);
      logic [8:0] nx;
      nx = node_fwd[ref_n];
      node_fwd[ref_n] = n;
      node_bwd[n] = ref_n;
      node_fwd[n] = nx;
      if (nx != NIL) node_bwd[nx] = n;
      else head_last[h] = n;
   endfunction

   function automatic void link_before(int h, logic [8:0] ref_n, logic [8:0] n);
      logic [8:0] pv;
      pv = node_bwd[ref_n];
      node_bwd[ref_n] = n;
      node_fwd[n] = ref_n;
      node_bwd[n] = pv;
      if (pv != NIL) node_fwd[pv] = n;
      else head_first[h] = n;
   endfunction

   function automatic logic [1:0] place_item(int h, logic [31:0] item, bit after);
      logic [8:0] n;
      n = take_node(item);
      if (n == NIL) return STS_NODE_EMPTY;
      if (head_len[h] == 0 || head_first[h] == NIL) begin
         head_first[h] = n;
         head_last[h] = n;
      end else if (head_pos[h] == POS_BEFORE) begin
         link_before(h, head_first[h], n);
      end else if (head_pos[h] == POS_PAST || head_cur[h] == NIL) begin
         link_after(h, head_last[h], n);
      end else if (after) begin
         link_after(h, head_cur[h], n);
      end else begin
         link_before(h, head_cur[h], n);
      end
      head_cur[h] = n;
      head_pos[h] = POS_ON;
      head_len[h]++;
      return STS_OK;
   endfunction

   function automatic void model_reset();
      for (int i = 0; i < HEADS; i++) begin
         clear_head(i);
         head_used[i] = 0;
         head_stack[i] = 4'(i);
      end
      head_top = HEADS - 1;
      for (int i = 0; i < NODES; i++) begin
         node_fwd[i] = NIL;
         node_bwd[i] = (i == 0) ? NIL : 9'(i - 1);
         node_item[i] = '0;
      end
      pool_top = 9'(NODES - 1);
      pool_total = 9'(NODES);
   endfunction

   function automatic rsp_type predict_rsp(logic [3:0] fn, logic [3:0] hh, logic [3:0] hh2,
                                           logic [31:0] item);
      rsp_type r;
      int h, h2;
      logic [8:0] c, nx, pv;
      r = '0;
      h = hh;
      h2 = hh2;
      if (fn == FN_CREATE) begin
         if (head_top < 0) begin
            r.status = STS_LIST_EMPTY;
         end else begin
            c = 9'(head_stack[head_top]);
            head_top--;
            clear_head(c);
            head_used[c] = 1;
            r.new_list = c[3:0];
         end
      end else if (fn == FN_BAD) begin
      end else if (!head_used[h]) begin
         r.status = STS_NOT_USED;
      end else begin
         case (func_type'(fn))
            FN_FIRST, FN_LAST: begin
               if (head_len[h] != 0) begin
                  c = (fn == FN_FIRST) ? head_first[h] : head_last[h];
                  head_cur[h] = c;
                  head_pos[h] = POS_ON;
                  r.item = node_item[c];
                  r.present = 1;
               end
            end
            FN_NEXT: begin
               if (head_pos[h] == POS_ON && head_cur[h] != NIL) begin
                  c = node_fwd[head_cur[h]];
                  head_cur[h] = c;
                  if (c == NIL) head_pos[h] = POS_PAST;
                  else begin
                     r.item = node_item[c];
                     r.present = 1;
                  end
               end else if (head_pos[h] == POS_BEFORE && head_first[h] != NIL) begin
                  c = head_first[h];
                  head_cur[h] = c;
                  head_pos[h] = POS_ON;
                  r.item = node_item[c];
                  r.present = 1;
               end
            end
            FN_PREV: begin
               if (head_pos[h] == POS_ON && head_cur[h] != NIL) begin
                  c = node_bwd[head_cur[h]];
                  head_cur[h] = c;
                  if (c == NIL) head_pos[h] = POS_BEFORE;
                  else begin
                     r.item = node_item[c];
                     r.present = 1;
                  end
               end else if (head_pos[h] == POS_PAST && head_last[h] != NIL) begin
                  c = head_last[h];
                  head_cur[h] = c;
                  head_pos[h] = POS_ON;
                  r.item = node_item[c];
                  r.present = 1;
               end
            end
            FN_CURRENT: begin
               if (head_pos[h] == POS_ON && head_cur[h] != NIL) begin
                  r.item = node_item[head_cur[h]];
                  r.present = 1;
               end
            end
            FN_ADD, FN_INSERT: r.status = place_item(h, item, fn == FN_ADD);
            FN_APPEND, FN_PREPEND: begin
               if (head_len[h] != 0) begin
                  head_cur[h] = (fn == FN_APPEND) ? head_last[h] : head_first[h];
                  head_pos[h] = POS_ON;
               end
               r.status = place_item(h, item, fn == FN_APPEND);
            end
            FN_REMOVE: begin
               c = head_cur[h];
               if (head_pos[h] == POS_ON && c != NIL) begin
                  nx = node_fwd[c];
                  pv = node_bwd[c];
                  if (pv != NIL) node_fwd[pv] = nx; else head_first[h] = nx;
                  if (nx != NIL) node_bwd[nx] = pv; else head_last[h] = pv;
                  head_cur[h] = nx;
                  head_pos[h] = (nx == NIL) ? POS_PAST : POS_ON;
                  head_len[h]--;
                  if (head_len[h] == 0) clear_head(h);
                  r.item = node_item[c];
                  r.present = 1;
                  give_node(c);
               end
            end
            FN_TRIM: begin
               c = head_last[h];
               if (head_len[h] != 0 && c != NIL) begin
                  pv = node_bwd[c];
                  head_last[h] = pv;
                  if (pv == NIL) head_first[h] = NIL; else node_fwd[pv] = NIL;
                  head_cur[h] = pv;
                  head_pos[h] = POS_ON;
                  head_len[h]--;
                  if (head_len[h] == 0) clear_head(h);
                  r.item = node_item[c];
                  r.present = 1;
                  give_node(c);
               end
            end
            FN_CONCAT: begin
               if (!head_used[h2]) begin
                  r.status = STS_NOT_USED;
               end else if (h2 != h) begin
                  if (head_len[h2] != 0) begin
                     if (head_len[h] == 0) begin
                        head_first[h] = head_first[h2];
                        head_last[h]  = head_last[h2];
                        head_cur[h]   = head_cur[h2];
                        head_pos[h]   = head_pos[h2];
                        head_len[h]   = head_len[h2];
                     end else begin
                        node_fwd[head_last[h]] = head_first[h2];
                        node_bwd[head_first[h2]] = head_last[h];
                        head_last[h] = head_last[h2];
                        head_len[h] = head_len[h] + head_len[h2];
                     end
                  end
                  release_head(h2);
               end
            end
            FN_FREE: begin
               if (head_len[h] != 0 && head_first[h] != NIL) begin
                  node_bwd[head_first[h]] = pool_top;
                  pool_top = head_last[h];
                  pool_total = pool_total + head_len[h];
               end
               release_head(h);
            end
            default: ;
         endcase
         r.count = head_len[h];
      end
      return r;
   endfunction

   task automatic send_txn(logic [3:0] fn, logic [3:0] h, logic [3:0] h2,
                           logic [31:0] item, logic typed, rsp_type exp);
      int gap;
      rsp_type pred;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_list_id <= h;
      req_other_list_id <= h2;
      req_item_value <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = predict_rsp(fn, h, h2, item);
      pending_rsp.push_back(typed ? exp : pred);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_list();
      logic [3:0] used_ids[$];
      for (int i = 0; i < HEADS; i++) if (head_used[i]) used_ids.push_back(4'(i));
      if (used_ids.size() != 0 && $urandom_range(0, 99) < 85)
         return used_ids[$urandom_range(0, used_ids.size() - 1)];
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [31:0] pick_item();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_txns(int n, int create_pct, int free_pct);
      int r;
      logic [3:0] fn;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < create_pct) fn = FN_CREATE;
         else if (r < create_pct + free_pct) fn = FN_FREE;
         else if (r < create_pct + free_pct + 4) fn = FN_CONCAT;
         else if (r < create_pct + free_pct + 6) fn = FN_BAD;
         else fn = 4'($urandom_range(FN_COUNT, FN_TRIM));
         send_txn(fn, pick_list(), pick_list(), pick_item(), 1'b0, '0);
      end
   endtask

   dir_row_type dir_rows[] = '{
      '{FN_COUNT,   4'd0,  4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_NOT_USED, 9'd0, 4'd0}},
      '{FN_CREATE,  4'd0,  4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd15}},
      '{FN_FIRST,   4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_NEXT,    4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_PREV,    4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_CURRENT, 4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_REMOVE,  4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_TRIM,    4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_APPEND,  4'd15, 4'd0,  32'hFFFFFFFF, 1'b1, '{32'h0, 1'b0, STS_OK, 9'd1, 4'd0}},
      '{FN_PREPEND, 4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd2, 4'd0}},
      '{FN_FIRST,   4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b1, STS_OK, 9'd2, 4'd0}},
      '{FN_LAST,    4'd15, 4'd0,  32'h0,        1'b1, '{32'hFFFFFFFF, 1'b1, STS_OK, 9'd2, 4'd0}},
      '{FN_NEXT,    4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd2, 4'd0}},
      '{FN_PREV,    4'd15, 4'd0,  32'h0,        1'b1, '{32'hFFFFFFFF, 1'b1, STS_OK, 9'd2, 4'd0}},
      '{FN_ADD,     4'd15, 4'd0,  32'h5,        1'b0, '0},
      '{FN_INSERT,  4'd15, 4'd0,  32'hA5A5A5A5, 1'b0, '0},
      '{FN_CREATE,  4'd0,  4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd14}},
      '{FN_APPEND,  4'd14, 4'd0,  32'h1,        1'b0, '0},
      '{FN_CONCAT,  4'd15, 4'd14, 32'h0,        1'b0, '0},
      '{FN_CONCAT,  4'd15, 4'd14, 32'h0,        1'b1, '{32'h0, 1'b0, STS_NOT_USED, 9'd5, 4'd0}},
      '{FN_CONCAT,  4'd15, 4'd15, 32'h0,        1'b0, '0},
      '{FN_REMOVE,  4'd15, 4'd0,  32'h0,        1'b0, '0},
      '{FN_TRIM,    4'd15, 4'd0,  32'h0,        1'b0, '0},
      '{FN_FREE,    4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_OK, 9'd0, 4'd0}},
      '{FN_BAD,     4'd7,  4'd3,  32'h12345678, 1'b1, '0},
      '{FN_COUNT,   4'd15, 4'd0,  32'h0,        1'b1, '{32'h0, 1'b0, STS_NOT_USED, 9'd0, 4'd0}}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response checker and receiver stall pattern
   int stall_pct = 0;
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result_item, rsp_item_present, rsp_status, rsp_item_count,
                    rsp_new_list};
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected response %p", $time, got);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.item !== want.item) begin
                  $display("%0t result_item exp %h got %h", $time, want.item, got.item);
                  errors++;
               end
               if (got.present !== want.present) begin
                  $display("%0t item_present exp %b got %b", $time, want.present,
                           got.present);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                  errors++;
               end
               if (got.count !== want.count) begin
                  $display("%0t item_count exp %0d got %0d", $time, want.count, got.count);
                  errors++;
               end
               if (got.new_list !== want.new_list) begin
                  $display("%0t new_list exp %0d got %0d", $time, want.new_list,
                           got.new_list);
                  errors++;
               end
            end
         end
         if (cycles % 97 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_list_id = '0;
      req_other_list_id = '0;
      req_item_value = '0;
      rsp_ready = 1'b0;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_txn(dir_rows[i].fn, dir_rows[i].h, dir_rows[i].h2, dir_rows[i].item,
                  dir_rows[i].typed, dir_rows[i].exp);

      random_txns(400, 6, 3);
      drain();

      // exhaust the free head stack
      for (int i = 0; i < HEADS + 2; i++)
         send_txn(FN_CREATE, 4'($urandom_range(0, 15)), 4'd0, pick_item(), 1'b0, '0);
      // exhaust the node pool
      for (int i = 0; i < NODES + 12; i++)
         send_txn(4'($urandom_range(FN_ADD, FN_PREPEND)), pick_list(), 4'd0, pick_item(),
                  1'b0, '0);
      random_txns(150, 2, 2);
      random_txns(450, 6, 5);

      drain();
      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
